### sv/dtse_pkg.sv
// ----------------------------------------------------------------------------
// dtse_pkg: shared types and constants of the DMA transfer and search engine
// Item operation codes, result kinds, register indexes, flag bit positions
// and the queue entry that passes from the front end to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtse_pkg;

	// Input item operations.
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_SERVICE = 2'd1,
		OP_DATA    = 2'd2
	} op_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_IRQ   = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_COMMAND       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_A_IS_SOURCE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PORT_A_FLAGS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PORT_B_FLAGS  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TRANSFER_MODE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MATCH_PATTERN = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_INT_SETUP     = 3'd7;

	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned BUS_ADDR_W = 16;

	// Port flag bit positions.
	localparam int unsigned PF_IO    = 3;
	localparam int unsigned PF_INC   = 4;
	localparam int unsigned PF_FIXED = 5;

	// Transfer mode encodings of bits 1:0.
	localparam logic [1:0] MODE_BYTE       = 2'd0;
	localparam logic [1:0] MODE_CONTINUOUS = 2'd1;

	// Interrupt flag bits (bits 15:8 of the interrupt setup).
	localparam int unsigned IF_MATCH  = 0;
	localparam int unsigned IF_END    = 1;
	localparam int unsigned IF_MODIFY = 5;
	localparam int unsigned INT_ENABLE_BIT = 16;

	localparam logic [7:0]  VEC_MATCH     = 8'd2;
	localparam logic [7:0]  VEC_END       = 8'd4;
	localparam logic [7:0]  VEC_KEEP_MASK = 8'hF9;
	localparam logic [15:0] LEN_UNBOUNDED = 16'hFFFF;

	// Result queue geometry.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration write.
	typedef struct packed {
		logic                  we;
		logic [REG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// One result.
	typedef struct packed {
		kind_t                 kind;
		logic [BUS_ADDR_W-1:0] addr;
		logic                  io;
		logic [7:0]            data;
	} res_t;

	// All results of one item: one or two, sharing the flags after the item.
	typedef struct packed {
		logic two;
		logic end_f;
		logic match_f;
		res_t res0;
		res_t res1;
	} entry_t;

endpackage

`default_nettype wire

### sv/dtse_front.sv
// ----------------------------------------------------------------------------
// dtse_front: item classification and engine state
// Holds the configuration registers, the port addresses, the byte count and
// the flags; decides for each accepted item which results it causes and
// pushes them as one entry into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtse_front
	import dtse_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_wr_t               cfg,
	input  wire logic                  accept,
	input  wire logic [1:0]            operation,
	input  wire logic [BUS_ADDR_W-1:0] address_a,
	input  wire logic [BUS_ADDR_W-1:0] address_b,
	input  wire logic                  ready_req,
	input  wire logic [7:0]            read_data,
	output logic                       q_push,
	output entry_t                     q_entry
);

	localparam int unsigned AW = ADDR_BITS;

	// Configuration registers.
	logic [1:0]  command_q;
	logic        a_src_q;
	logic [7:0]  pa_flags_q, pb_flags_q;
	logic [2:0]  mode_q;
	logic [15:0] pattern_q;
	logic [15:0] blen_q;
	logic [16:0] irq_q;

	// Engine state.
	logic [AW-1:0] pa_addr_q, pb_addr_q;
	logic [15:0]   bytes_q;
	logic          end_q, match_q, en_q, pend_q;

	logic [AW-1:0] pa_addr_n, pb_addr_n;
	logic [15:0]   bytes_n;
	logic          end_n, match_n, en_n, pend_n;

	// Next address of a port after one byte.
	function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] a, input logic [7:0] fl);
		logic [AW-1:0] r;
		if (fl[PF_FIXED]) begin
			r = a;
		end else if (fl[PF_INC]) begin
			r = a + AW'(1);
		end else begin
			r = a - AW'(1);
		end
		return r;
	endfunction

	// Internal address onto the bus address width.
	function automatic logic [BUS_ADDR_W-1:0] to_bus(input logic [AW-1:0] a);
		logic [AW+BUS_ADDR_W-1:0] ext;
		ext = {{BUS_ADDR_W{1'b0}}, a};
		return ext[BUS_ADDR_W-1:0];
	endfunction

	// Start address from the input onto the internal width.
	function automatic logic [AW-1:0] from_bus(input logic [BUS_ADDR_W-1:0] a);
		logic [AW+BUS_ADDR_W-1:0] ext;
		ext = {{AW{1'b0}}, a};
		return ext[AW-1:0];
	endfunction

	// Source and destination views of the two ports.
	logic [AW-1:0] src_addr, dst_addr, src_next, dst_next;
	logic [7:0]    sfl, dfl;
	logic          ready_bad;

	assign src_addr  = a_src_q ? pa_addr_q : pb_addr_q;
	assign dst_addr  = a_src_q ? pb_addr_q : pa_addr_q;
	assign sfl       = a_src_q ? pa_flags_q : pb_flags_q;
	assign dfl       = a_src_q ? pb_flags_q : pa_flags_q;
	assign ready_bad = (mode_q[1:0] != MODE_CONTINUOUS) && (ready_req != mode_q[2]);
	assign src_next  = ready_bad ? src_addr : step_addr(src_addr, sfl);
	assign dst_next  = ready_bad ? dst_addr : step_addr(dst_addr, dfl);

	// Service acceptance.
	logic svc_ok;
	assign svc_ok = (command_q != 2'd0) && en_q && !end_q && !pend_q &&
		!(command_q[1] && match_q) && !ready_bad;

	// Outcome of a data step.
	logic [15:0] bytes_inc;
	logic        len_bounded, hit, end_data, match_data, cont;
	assign bytes_inc   = bytes_q + 16'd1;
	assign len_bounded = (blen_q != 16'd0) && (blen_q != LEN_UNBOUNDED);
	assign end_data    = end_q || (bytes_inc == 16'd0) || (len_bounded && (bytes_inc > blen_q));
	assign hit         = ((read_data ^ pattern_q[7:0]) & ~pattern_q[15:8]) == 8'd0;
	assign match_data  = match_q || (command_q[1] && hit);
	assign cont        = (mode_q[1:0] != MODE_BYTE) && !ready_bad && !end_data &&
		!(command_q[1] && match_data);

	// Interrupt vector when the run stops.
	logic [7:0] ifl, vect_base, vect;
	logic       irq_fire;
	always_comb begin
		ifl = irq_q[15:8];
		if (ifl[IF_MATCH] && match_data) begin
			vect_base = VEC_MATCH;
		end else if (ifl[IF_END] && end_data) begin
			vect_base = VEC_END;
		end else begin
			vect_base = 8'd0;
		end
		irq_fire = irq_q[INT_ENABLE_BIT] && (vect_base != 8'd0);
		vect = ifl[IF_MODIFY] ? (vect_base + (irq_q[7:0] & VEC_KEEP_MASK)) : irq_q[7:0];
	end

	// Results of the item and next state.
	res_t r_read_svc, r_write, r_second;
	logic has_second;
	always_comb begin
		r_read_svc = '{kind: KIND_READ, addr: to_bus(src_addr), io: sfl[PF_IO], data: 8'd0};
		r_write    = '{kind: KIND_WRITE, addr: to_bus(dst_addr), io: dfl[PF_IO],
			data: read_data};
		if (cont) begin
			r_second = '{kind: KIND_READ, addr: to_bus(src_next), io: sfl[PF_IO], data: 8'd0};
		end else begin
			r_second = '{kind: KIND_IRQ, addr: '0, io: 1'b0, data: vect};
		end
		has_second = cont || irq_fire;

		pa_addr_n = pa_addr_q;
		pb_addr_n = pb_addr_q;
		bytes_n   = bytes_q;
		end_n     = end_q;
		match_n   = match_q;
		en_n      = en_q;
		pend_n    = pend_q;
		q_push    = 1'b0;
		q_entry   = '0;

		if (accept) begin
			case (operation)
				OP_START: begin
					pa_addr_n = from_bus(address_a);
					pb_addr_n = from_bus(address_b);
					bytes_n   = 16'd0;
					end_n     = 1'b0;
					match_n   = 1'b0;
					en_n      = 1'b1;
					pend_n    = 1'b0;
				end
				OP_SERVICE: begin
					if (svc_ok) begin
						pend_n          = 1'b1;
						q_push          = 1'b1;
						q_entry.res0    = r_read_svc;
						q_entry.end_f   = end_q;
						q_entry.match_f = match_q;
					end
				end
				OP_DATA: begin
					if (pend_q) begin
						pend_n  = cont;
						bytes_n = bytes_inc;
						end_n   = end_data;
						match_n = match_data;
						if (a_src_q) begin
							pa_addr_n = src_next;
							pb_addr_n = dst_next;
						end else begin
							pb_addr_n = src_next;
							pa_addr_n = dst_next;
						end
						q_entry.end_f   = end_data;
						q_entry.match_f = match_data;
						if (command_q[0]) begin
							q_push       = 1'b1;
							q_entry.res0 = r_write;
							q_entry.res1 = r_second;
							q_entry.two  = has_second;
						end else begin
							q_push       = has_second;
							q_entry.res0 = r_second;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q  <= '0;
			a_src_q    <= 1'b0;
			pa_flags_q <= '0;
			pb_flags_q <= '0;
			mode_q     <= '0;
			pattern_q  <= '0;
			blen_q     <= '0;
			irq_q      <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_COMMAND:       command_q  <= cfg.data[1:0];
				REG_A_IS_SOURCE:   a_src_q    <= cfg.data[0];
				REG_PORT_A_FLAGS:  pa_flags_q <= cfg.data[7:0];
				REG_PORT_B_FLAGS:  pb_flags_q <= cfg.data[7:0];
				REG_TRANSFER_MODE: mode_q     <= cfg.data[2:0];
				REG_MATCH_PATTERN: pattern_q  <= cfg.data[15:0];
				REG_BLOCK_LENGTH:  blen_q     <= cfg.data[15:0];
				REG_INT_SETUP:     irq_q      <= cfg.data[16:0];
				default: begin
				end
			endcase
		end
	end

	// Engine state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_addr_q <= '0;
			pb_addr_q <= '0;
			bytes_q   <= '0;
			end_q     <= 1'b0;
			match_q   <= 1'b0;
			en_q      <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			pa_addr_q <= pa_addr_n;
			pb_addr_q <= pb_addr_n;
			bytes_q   <= bytes_n;
			end_q     <= end_n;
			match_q   <= match_n;
			en_q      <= en_n;
			pend_q    <= pend_n;
		end
	end

`ifndef SYNTH
	// A read can only be outstanding on an enabled engine.
	a_pend_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> en_q)
		else $error("read pending while engine disabled");

	// The end flag is raised only by a data step.
	a_end_by_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(end_q) |-> $past(accept && (operation == OP_DATA)))
		else $error("end flag rose without a data item");

	// A second result is only ever paired with a write.
	a_two_has_write: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_entry.two) |-> (q_entry.res0.kind == KIND_WRITE))
		else $error("two results without a leading write");
`endif

endmodule

`default_nettype wire

### sv/dtse_queue.sv
// ----------------------------------------------------------------------------
// dtse_queue: result queue and issue stage
// Stores the result entries of accepted items and hands them out one result
// at a time, oldest first, marking the final result of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module dtse_queue
	import dtse_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_push,
	input  wire entry_t            q_entry,
	output logic                   full,
	output logic                   empty,
	input  wire logic              pop,
	output logic [1:0]             kind,
	output logic [BUS_ADDR_W-1:0]  bus_address,
	output logic                   is_io,
	output logic [7:0]             bus_data,
	output logic                   end_reached,
	output logic                   match_found,
	output logic                   last_result
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              sub_q;

	entry_t head;
	res_t   cur;
	logic   pop_ok, pop_item;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (cnt_q == QCNT_W'(0));
	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

	// Current result of the head entry.
	assign cur         = sub_q ? head.res1 : head.res0;
	assign last_result = head.two ? sub_q : 1'b1;
	assign kind        = cur.kind;
	assign bus_address = cur.addr;
	assign is_io       = cur.io;
	assign bus_data    = cur.data;
	assign end_reached = head.end_f;
	assign match_found = head.match_f;

	assign pop_ok   = pop && !empty;
	assign pop_item = pop_ok && last_result;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= q_entry;
		end
	end

	// Pointers, fill count and position within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_item) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
				sub_q    <= 1'b0;
			end else if (pop_ok) begin
				sub_q <= 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(q_push) - QCNT_W'(pop_item);
		end
	end

`ifndef SYNTH
	// Never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !full)
		else $error("push into a full result queue");

	// Second position only within an entry that holds two results.
	a_sub_two: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q && !empty) |-> head.two)
		else $error("second result selected in a single-result entry");

	// Taking a non-final result moves on to the second one of the same entry.
	a_sub_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && !last_result) |=> (sub_q && $stable(rd_ptr_q)))
		else $error("head entry left before its final result");
`endif

endmodule

`default_nettype wire

### sv/dma_transfer_search_engine_top.sv
// ----------------------------------------------------------------------------
// dma_transfer_search_engine_top: two-port byte DMA with transfer and search
// Top level joining the front end with the result queue.
// ----------------------------------------------------------------------------
// An item is taken in every cycle in which push is high and full is low; the
// front end decides its results in that same cycle and stores them in a
// four-entry result queue behind any older results. The result side issues
// one result per cycle while pop is high and empty is low: a service item
// gives at most one result, a data item up to two (a write followed by the
// next read or an interrupt vector), so a transfer step of one service and
// one data item, or of one data item in continuous and burst mode, needs a
// read and a write result. full rises only when the queue holds four entries
// that the consumer has not taken. Configuration registers are written with
// wr_en, wr_index and wr_data at any edge and act from the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_transfer_search_engine_top
	import dtse_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            operation,
	input  wire logic [BUS_ADDR_W-1:0] address_a,
	input  wire logic [BUS_ADDR_W-1:0] address_b,
	input  wire logic                  ready_req,
	input  wire logic [7:0]            read_data,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [1:0]                 kind,
	output logic [BUS_ADDR_W-1:0]      bus_address,
	output logic                       is_io,
	output logic [7:0]                 bus_data,
	output logic                       end_reached,
	output logic                       match_found,
	output logic                       last_result
);

	cfg_wr_t cfg;
	entry_t  q_entry;
	logic    q_push, accept;

	assign cfg    = '{we: wr_en, index: wr_index, data: wr_data};
	assign accept = push && !full;

	// Front end: classification and engine state.
	dtse_front #(
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.operation (operation),
		.address_a (address_a),
		.address_b (address_b),
		.ready_req (ready_req),
		.read_data (read_data),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	// Back end: result queue and issue.
	dtse_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.full        (full),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.bus_address (bus_address),
		.is_io       (is_io),
		.bus_data    (bus_data),
		.end_reached (end_reached),
		.match_found (match_found),
		.last_result (last_result)
	);

endmodule

`default_nettype wire
